/* hdl/gtpu_pkg.sv */
// Shared types and constants for the GIF tag packet unpacker.
package gtpu_pkg;

  // Parsing mode of the unpacker
  typedef enum logic [1:0] {
    MODE_TAG     = 2'd0,
    MODE_PACKED  = 2'd1,
    MODE_REGLIST = 2'd2,
    MODE_IMAGE   = 2'd3
  } mode_e;

  // Data format field of a tag
  localparam logic [1:0] FLG_PACKED  = 2'd0;
  localparam logic [1:0] FLG_REGLIST = 2'd1;

  // Register descriptors
  localparam logic [3:0] DESC_PRIM  = 4'h0;
  localparam logic [3:0] DESC_RGBAQ = 4'h1;
  localparam logic [3:0] DESC_ST    = 4'h2;
  localparam logic [3:0] DESC_UV    = 4'h3;
  localparam logic [3:0] DESC_XYZF2 = 4'h4;
  localparam logic [3:0] DESC_XYZ2  = 4'h5;
  localparam logic [3:0] DESC_FOG   = 4'hA;
  localparam logic [3:0] DESC_AD    = 4'hE;

  // Target register addresses
  localparam logic [7:0] REG_PRIM  = 8'h00;
  localparam logic [7:0] REG_RGBAQ = 8'h01;
  localparam logic [7:0] REG_ST    = 8'h02;
  localparam logic [7:0] REG_UV    = 8'h03;
  localparam logic [7:0] REG_XYZF2 = 8'h04;
  localparam logic [7:0] REG_XYZ2  = 8'h05;
  localparam logic [7:0] REG_FOG   = 8'h0A;
  localparam logic [7:0] REG_XYZF3 = 8'h0C;
  localparam logic [7:0] REG_XYZ3  = 8'h0D;

  // Transfer direction that lets image data through
  localparam logic [1:0] DIR_HOST_TO_LOCAL = 2'd0;

  // Result kinds
  localparam logic KIND_REG   = 1'b0;
  localparam logic KIND_IMAGE = 1'b1;

  // Depth of the result queue
  localparam int unsigned QDEPTH = 3;

  typedef struct packed {
    logic        kind;
    logic [7:0]  reg_addr;
    logic [63:0] data_low;
    logic [63:0] data_high;
    logic        last;
  } result_t;

  typedef struct packed {
    mode_e       mode;
    logic [14:0] loops_left;
    logic [4:0]  regs_per_loop;
    logic [3:0]  reg_position;
    logic [63:0] descriptors;
    logic [31:0] current_rgba;
    logic [31:0] current_q;
  } state_t;

endpackage

/* hdl/gtpu_qw_if.sv */
// Quadword input channel.
interface gtpu_qw_if;
  logic        valid;
  logic        ready;
  logic [31:0] word0;
  logic [31:0] word1;
  logic [31:0] word2;
  logic [31:0] word3;

  modport source (output valid, output word0, output word1, output word2, output word3,
                  input ready);
  modport sink (input valid, input word0, input word1, input word2, input word3,
                output ready);
endinterface

/* hdl/gtpu_res_if.sv */
// Result output channel.
interface gtpu_res_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  reg_addr;
  logic [63:0] data_low;
  logic [63:0] data_high;
  logic        last;

  modport source (output valid, output kind, output reg_addr, output data_low,
                  output data_high, output last, input ready);
  modport sink (input valid, input kind, input reg_addr, input data_low,
                input data_high, input last, output ready);
endinterface

/* hdl/gtpu_cfg_if.sv */
// Configuration write channel.
interface gtpu_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hdl/gtpu_unpack.sv */
// Decode of one quadword against the parser state into up to two results.
module gtpu_unpack (
  input  gtpu_pkg::state_t  state_i,
  input  logic [1:0]        dir_i,
  input  logic [31:0]       word0_i,
  input  logic [31:0]       word1_i,
  input  logic [31:0]       word2_i,
  input  logic [31:0]       word3_i,
  output gtpu_pkg::state_t  state_o,
  output logic [1:0]        num_o,
  output gtpu_pkg::result_t res0_o,
  output gtpu_pkg::result_t res1_o
);

  function automatic gtpu_pkg::result_t reg_wr(logic [7:0] addr, logic [63:0] data);
    gtpu_pkg::result_t r;
    r.kind      = gtpu_pkg::KIND_REG;
    r.reg_addr  = addr;
    r.data_low  = data;
    r.data_high = '0;
    r.last      = 1'b0;
    return r;
  endfunction

  // Step to the next descriptor; close the packet when the loops run out
  function automatic gtpu_pkg::state_t advance(gtpu_pkg::state_t s);
    gtpu_pkg::state_t r;
    logic [4:0]       nxt;
    r   = s;
    nxt = {1'b0, s.reg_position} + 5'd1;
    if (nxt >= s.regs_per_loop) begin
      r.reg_position = '0;
      r.loops_left   = s.loops_left - 15'd1;
      if (r.loops_left == '0) begin
        r.mode = gtpu_pkg::MODE_TAG;
      end
    end else begin
      r.reg_position = nxt[3:0];
    end
    return r;
  endfunction

  function automatic logic [3:0] cur_desc(gtpu_pkg::state_t s);
    return s.descriptors[{s.reg_position, 2'b00} +: 4];
  endfunction

  logic [63:0]      low64;
  logic [63:0]      high64;
  logic [3:0]       desc0;
  logic [3:0]       desc1;
  logic [31:0]      rgba;
  logic [1:0]       flg;
  logic [3:0]       cnt;
  gtpu_pkg::state_t st1;
  gtpu_pkg::result_t r0;
  gtpu_pkg::result_t r1;
  logic [1:0]       num;

  assign low64  = {word1_i, word0_i};
  assign high64 = {word3_i, word2_i};
  assign rgba   = {word3_i[7:0], word2_i[7:0], word1_i[7:0], word0_i[7:0]};
  assign flg    = word1_i[27:26];
  assign cnt    = word1_i[31:28];
  assign desc0  = cur_desc(state_i);

  always_comb begin
    state_o = state_i;
    st1     = advance(state_i);
    desc1   = cur_desc(st1);
    r0      = reg_wr(gtpu_pkg::REG_PRIM, '0);
    r1      = reg_wr(gtpu_pkg::REG_PRIM, '0);
    num     = 2'd0;
    unique case (state_i.mode)
      gtpu_pkg::MODE_TAG: begin
        state_o.loops_left    = word0_i[14:0];
        state_o.regs_per_loop = (cnt == 4'd0) ? 5'd16 : {1'b0, cnt};
        state_o.reg_position  = '0;
        state_o.descriptors   = high64;
        if (flg == gtpu_pkg::FLG_PACKED && word1_i[14]) begin
          r0  = reg_wr(gtpu_pkg::REG_PRIM, {53'd0, word1_i[25:15]});
          num = 2'd1;
        end
        if (word0_i[14:0] == '0) begin
          state_o.mode = gtpu_pkg::MODE_TAG;
        end else if (flg == gtpu_pkg::FLG_PACKED) begin
          state_o.mode = gtpu_pkg::MODE_PACKED;
        end else if (flg == gtpu_pkg::FLG_REGLIST) begin
          state_o.mode = gtpu_pkg::MODE_REGLIST;
        end else begin
          state_o.mode = gtpu_pkg::MODE_IMAGE;
        end
      end
      gtpu_pkg::MODE_PACKED: begin
        state_o = st1;
        num     = 2'd1;
        case (desc0)
          gtpu_pkg::DESC_PRIM: r0 = reg_wr(gtpu_pkg::REG_PRIM, low64);
          gtpu_pkg::DESC_RGBAQ: begin
            r0 = reg_wr(gtpu_pkg::REG_RGBAQ, {state_i.current_q, rgba});
            state_o.current_rgba = rgba;
          end
          gtpu_pkg::DESC_ST: begin
            r0 = reg_wr(gtpu_pkg::REG_ST, low64);
            r1 = reg_wr(gtpu_pkg::REG_RGBAQ, {word2_i, state_i.current_rgba});
            state_o.current_q = word2_i;
            num = 2'd2;
          end
          gtpu_pkg::DESC_UV:
            r0 = reg_wr(gtpu_pkg::REG_UV,
                        {32'd0, 1'b0, word1_i[14:0], 1'b0, word0_i[14:0]});
          gtpu_pkg::DESC_XYZF2:
            r0 = reg_wr(word3_i[15] ? gtpu_pkg::REG_XYZF3 : gtpu_pkg::REG_XYZF2,
                        {word3_i[15:8], word2_i[27:4], word1_i[15:0], word0_i[15:0]});
          gtpu_pkg::DESC_XYZ2:
            r0 = reg_wr(word3_i[15] ? gtpu_pkg::REG_XYZ3 : gtpu_pkg::REG_XYZ2,
                        {word2_i, word1_i[15:0], word0_i[15:0]});
          gtpu_pkg::DESC_FOG:
            r0 = reg_wr(gtpu_pkg::REG_FOG, {word3_i[11:4], 56'd0});
          gtpu_pkg::DESC_AD: r0 = reg_wr(word2_i[7:0], low64);
          default: num = 2'd0;
        endcase
      end
      gtpu_pkg::MODE_REGLIST: begin
        state_o = st1;
        if (desc0 < gtpu_pkg::DESC_AD) begin
          r0  = reg_wr({4'd0, desc0}, low64);
          num = 2'd1;
        end
        // Drop the high half once the packet has closed on the low half
        if (st1.mode != gtpu_pkg::MODE_TAG) begin
          state_o = advance(st1);
          if (desc1 < gtpu_pkg::DESC_AD) begin
            if (num == 2'd0) begin
              r0 = reg_wr({4'd0, desc1}, high64);
            end else begin
              r1 = reg_wr({4'd0, desc1}, high64);
            end
            num = num + 2'd1;
          end
        end
      end
      gtpu_pkg::MODE_IMAGE: begin
        if (dir_i == gtpu_pkg::DIR_HOST_TO_LOCAL) begin
          r0.kind      = gtpu_pkg::KIND_IMAGE;
          r0.data_low  = low64;
          r0.data_high = high64;
          num          = 2'd1;
        end
        state_o.loops_left = state_i.loops_left - 15'd1;
        if (state_o.loops_left == '0) begin
          state_o.mode = gtpu_pkg::MODE_TAG;
        end
      end
      default: ;
    endcase
    if (num == 2'd1) begin
      r0.last = 1'b1;
    end
    if (num == 2'd2) begin
      r1.last = 1'b1;
    end
  end

  assign num_o  = num;
  assign res0_o = r0;
  assign res1_o = r1;

endmodule

/* hdl/gif_tag_packet_unpacker.sv */
// GIF tag packet unpacker: quadwords in, register writes and image words out.
// A result is written into the registered result queue when its word is accepted
// and is offered once the results ahead of it have gone. Throughput: one word per
// cycle while each word gives at most one result and the output is ready; ST and
// reglist words can give two results; the three-entry queue has a single output.
// Reset: parser returns to tag mode with all state zero, queue empty, direction 0.
module gif_tag_packet_unpacker (
  input  logic       clk_i,
  input  logic       rst_ni,
  gtpu_qw_if.sink    in_i,
  gtpu_res_if.source out_o,
  gtpu_cfg_if.sink   cfg_i
);

  gtpu_pkg::state_t  state_q, state_d;
  gtpu_pkg::result_t res0, res1;
  gtpu_pkg::result_t queue_q [gtpu_pkg::QDEPTH];
  gtpu_pkg::result_t queue_d [gtpu_pkg::QDEPTH];
  logic [1:0]        count_q, count_d;
  logic [1:0]        count_pop;
  logic [1:0]        num;
  logic [1:0]        dir_q;
  logic              accept;
  logic              pop;

  gtpu_unpack u_unpack (
    .state_i (state_q),
    .dir_i   (dir_q),
    .word0_i (in_i.word0),
    .word1_i (in_i.word1),
    .word2_i (in_i.word2),
    .word3_i (in_i.word3),
    .state_o (state_d),
    .num_o   (num),
    .res0_o  (res0),
    .res1_o  (res1)
  );

  // Take a word only while the queue has room for two results
  assign in_i.ready  = (count_q <= 2'd1);
  assign accept      = in_i.valid && in_i.ready;
  assign pop         = (count_q != 2'd0) && out_o.ready;
  assign cfg_i.ready = 1'b1;

  assign out_o.valid     = (count_q != 2'd0);
  assign out_o.kind      = queue_q[0].kind;
  assign out_o.reg_addr  = queue_q[0].reg_addr;
  assign out_o.data_low  = queue_q[0].data_low;
  assign out_o.data_high = queue_q[0].data_high;
  assign out_o.last      = queue_q[0].last;

  always_comb begin
    count_pop = count_q - {1'b0, pop};
    for (int i = 0; i < gtpu_pkg::QDEPTH; i++) begin
      queue_d[i] = queue_q[i];
      if (pop && i < gtpu_pkg::QDEPTH - 1) begin
        queue_d[i] = queue_q[i + 1];
      end
    end
    for (int i = 0; i < gtpu_pkg::QDEPTH; i++) begin
      if (accept && num != 2'd0 && 2'(i) == count_pop) begin
        queue_d[i] = res0;
      end
      if (accept && num == 2'd2 && 2'(i) == count_pop + 2'd1) begin
        queue_d[i] = res1;
      end
    end
    count_d = accept ? count_pop + num : count_pop;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
      count_q <= '0;
      dir_q   <= gtpu_pkg::DIR_HOST_TO_LOCAL;
    end else begin
      count_q <= count_d;
      if (accept) begin
        state_q <= state_d;
      end
      if (cfg_i.valid) begin
        dir_q <= cfg_i.data;
      end
    end
  end

  // Hold payload; no reset needed
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < gtpu_pkg::QDEPTH; i++) begin
      queue_q[i] <= queue_d[i];
    end
  end

endmodule
